/* hw/rtl/tpp_pkg.sv */
// Shared widths, register indexes and control types for the throttle position PID.
package tpp_pkg;

	localparam int POS_W      = 12;  // target / actual position
	localparam int ERR_W      = 13;  // signed error
	localparam int ERR_MAG_W  = 12;  // |error| <= 4095
	localparam int DIFF_MAG_W = 13;  // |error - previous error| <= 8190
	localparam int GAIN_W     = 16;
	localparam int DUTY_W     = 10;
	localparam int INT_W      = 32;  // integral accumulator

	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = 3;

	localparam logic signed [POS_W-1:0] LOW_POS_LIMIT = 12'sd200;

	// Gain scale 1000 = 125 << 3: shift off the 8, then divide by 125 (125 >= 2**6)
	localparam int SCALE_SHIFT = 3;
	localparam int SCALE_ODD   = 125;
	localparam int ODD_LOG2    = 6;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FWD_P,
		REG_FWD_I,
		REG_FWD_D,
		REG_BACK_P,
		REG_BACK_I,
		REG_BACK_D,
		REG_LOW_BACK_P,
		REG_LOW_BACK_I
	} tpp_reg_t;

	// Load strobes for the two stages of a constant divider
	typedef struct packed {
		logic est;
		logic fix;
	} tpp_div_en_t;

endpackage

/* hw/rtl/tpp_if.sv */
// Item channels: position sample in, motor drive result out.
interface tpp_in_if import tpp_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] target_pos;
	logic signed [POS_W-1:0] actual_pos;
	logic                    clear_history;

	modport source (output valid, output target_pos, output actual_pos,
		output clear_history, input ready);
	modport sink (input valid, input target_pos, input actual_pos,
		input clear_history, output ready);
endinterface

interface tpp_out_if import tpp_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] pwm_duty;
	logic              reverse_dir;

	modport source (output valid, output pwm_duty, output reverse_dir, input ready);
	modport sink (input valid, input pwm_duty, input reverse_dir, output ready);
endinterface

/* hw/rtl/tpp_cdiv.sv */
// Two-stage unsigned divide by a constant: reciprocal estimate, then one-step correction.
module tpp_cdiv import tpp_pkg::*; #(
	parameter int NUM_W   = 29,
	parameter int DIVISOR = 5
) (
	input  logic             clk,
	input  tpp_div_en_t      en,
	input  logic [NUM_W-1:0] num,
	output logic [NUM_W-1:0] quo
);

	localparam logic [63:0] RECIP_L = (64'd1 << NUM_W) / DIVISOR;
	localparam int REC_W  = NUM_W + 1;
	localparam int PROD_W = NUM_W + REC_W;
	localparam logic [REC_W-1:0] RECIP = RECIP_L[REC_W-1:0];
	localparam logic [NUM_W-1:0] DIV_V = NUM_W'(DIVISOR);

	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0]  num_s1;
	logic [NUM_W-1:0]  qest_s1;
	logic [NUM_W-1:0]  rem;
	logic [NUM_W-1:0]  quo_s2;

	// estimate is floor(n/D) or one short of it
	assign prod = PROD_W'(num) * PROD_W'(RECIP);
	assign rem  = num_s1 - qest_s1 * DIV_V;
	assign quo  = quo_s2;

	always_ff @(posedge clk) begin
		if (en.est) begin
			num_s1  <= num;
			qest_s1 <= prod[PROD_W-2:NUM_W];
		end
		if (en.fix) begin
			quo_s2 <= qest_s1 + NUM_W'(rem >= DIV_V);
		end
	end

endmodule

/* hw/rtl/throttle_position_pid.sv */
// Top level of the throttle position PID: gain registers, ten-stage datapath, sign-change logic.
// A result is presented from stage 10 once its item has passed stages 1 to 10 in order.
// Throughput: one item per cycle; each stage holds one item and loads whenever it
//   is empty or its successor moves, so the block only stalls with all ten full.
// The integral accumulator closes its loop in stage 6 alone (add and saturate).
// Reset (arst_n low): gains, integral and previous error cleared, both sign-change
//   flags set, all stages emptied.
module throttle_position_pid import tpp_pkg::*; #(
	parameter int MAX_DUTY    = 999,
	parameter int TICK_PERIOD = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	tpp_in_if.sink               meas,
	tpp_out_if.source            drive
);

	// ---- widths ----------------------------------------------------------
	localparam int NSTG    = 10;
	localparam int P_W     = ERR_W + GAIN_W + 1;       // signed err * gain
	localparam int EIM_W   = ERR_MAG_W + GAIN_W;       // |err| * ki
	localparam int DDP_W   = DIFF_MAG_W + GAIN_W;      // |err - prev| * kd
	localparam int TICK_W  = $clog2(TICK_PERIOD + 1);
	localparam int IC_W    = EIM_W + TICK_W;           // tick * |err| * ki
	localparam int ICS_W   = IC_W - SCALE_SHIFT;
	localparam int IQ_W    = ICS_W - ODD_LOG2;         // integral increment magnitude
	localparam int PD_W    = P_W + 1;                  // P + D
	localparam int PDM_W   = PD_W - 1 - SCALE_SHIFT;
	localparam int PQ_W    = PDM_W - ODD_LOG2;         // (P + D) / 1000 magnitude
	localparam int RES_W   = INT_W + 1;
	localparam int DMAX_W  = $clog2(MAX_DUTY + 1);
	localparam int DSEL_W  = (DMAX_W > DUTY_W) ? DMAX_W : DUTY_W;

	localparam logic [IC_W-1:0]         TICK_V = IC_W'(TICK_PERIOD);
	localparam logic signed [RES_W-1:0] MAX_S  = RES_W'(MAX_DUTY);
	localparam logic [DSEL_W-1:0]       MAX_V  = DSEL_W'(MAX_DUTY);

	// ---- gain registers -------------------------------------------------
	logic [GAIN_W-1:0] gain_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) gain_q[i] <= '0;
		end else if (cfg_we) begin
			gain_q[cfg_index] <= cfg_data;
		end
	end

	// ---- stage handshake -------------------------------------------------
	// free[k]: stage k may load this cycle; load[k]: it does
	logic [NSTG:1]   vld;
	logic [NSTG+1:1] free;
	logic [NSTG:1]   src;
	logic [NSTG:1]   load;

	always_comb begin
		free[NSTG+1] = drive.ready;
		for (int k = NSTG; k >= 1; k--) free[k] = !vld[k] || free[k+1];
		src[1] = meas.valid;
		for (int k = 2; k <= NSTG; k++) src[k] = vld[k-1];
		load = free[NSTG:1] & src;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= load | (~free[NSTG:1] & vld);
		end
	end

	assign meas.ready  = free[1];
	assign drive.valid = vld[NSTG];

	// ---- entry: error, gain choice, sign-change flags ----------------------
	logic                    fwd_pend_q;
	logic                    back_pend_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic [INT_W-1:0]        integral_q;

	logic signed [ERR_W-1:0] err_c;
	logic signed [ERR_W-1:0] err_neg_c;
	logic signed [ERR_W-1:0] prev_eff_c;
	logic signed [ERR_W:0]   diff_c;
	logic signed [ERR_W:0]   diff_neg_c;
	logic                    pos_c;
	logic                    low_c;
	logic                    zint_c;
	logic [GAIN_W-1:0]       kp_c, ki_c, kd_c;

	always_comb begin
		err_c      = ERR_W'(meas.target_pos) - ERR_W'(meas.actual_pos);
		err_neg_c  = -err_c;
		prev_eff_c = meas.clear_history ? '0 : prev_err_q;
		diff_c     = (ERR_W+1)'(err_c) - (ERR_W+1)'(prev_eff_c);
		diff_neg_c = -diff_c;
		pos_c      = !err_c[ERR_W-1] && (err_c != '0);
		low_c      = meas.actual_pos <= LOW_POS_LIMIT;
		// integral restarts on a fault clear or on the first step of a new sign
		zint_c     = meas.clear_history || (pos_c ? fwd_pend_q : back_pend_q);
		if (pos_c) begin
			kp_c = gain_q[REG_FWD_P];
			ki_c = gain_q[REG_FWD_I];
			kd_c = gain_q[REG_FWD_D];
		end else begin
			kp_c = low_c ? gain_q[REG_LOW_BACK_P] : gain_q[REG_BACK_P];
			ki_c = low_c ? gain_q[REG_LOW_BACK_I] : gain_q[REG_BACK_I];
			kd_c = gain_q[REG_BACK_D];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_pend_q  <= 1'b1;
			back_pend_q <= 1'b1;
			prev_err_q  <= '0;
		end else if (load[1]) begin
			prev_err_q  <= err_c;
			fwd_pend_q  <= !pos_c;
			back_pend_q <= pos_c;
		end
	end

	// ---- datapath registers ---------------------------------------------------
	logic signed [ERR_W-1:0] err_s1;
	logic [ERR_MAG_W-1:0]    errm_s1;
	logic                    ein_s1;
	logic [DIFF_MAG_W-1:0]   ddm_s1;
	logic                    ddn_s1;
	logic [GAIN_W-1:0]       kp_s1, ki_s1, kd_s1;
	logic                    zint_s1;

	logic signed [P_W-1:0]   p_s2;
	logic [EIM_W-1:0]        eim_s2;
	logic [DDP_W-1:0]        ddp_s2;
	logic                    ein_s2, ddn_s2, zint_s2;

	logic signed [P_W-1:0]   p_s3;
	logic [IC_W-1:0]         icm_s3;
	logic                    ein_s3, ddn_s3, zint_s3;

	logic signed [P_W-1:0]   p_s4;
	logic                    ein_s4, ddn_s4, zint_s4;

	logic signed [PD_W-1:0]  pd_s5;
	logic                    ein_s5, zint_s5;

	logic [PDM_W-1:0]        pdm_s6;
	logic                    pdn_s6;
	logic [INT_W-1:0]        integ_s6;

	logic                    pdn_s7, pdn_s8;
	logic [INT_W-1:0]        integ_s7, integ_s8;

	logic signed [RES_W-1:0] res_s9;

	logic [DUTY_W-1:0]       duty_s10;
	logic                    rev_s10;

	// stage 2 products
	logic signed [P_W-1:0] err_x, kp_x, p_c;
	logic [EIM_W-1:0]      eim_c;
	logic [DDP_W-1:0]      ddp_c;

	assign err_x = P_W'(err_s1);
	assign kp_x  = P_W'({1'b0, kp_s1});
	assign p_c   = err_x * kp_x;
	assign eim_c = EIM_W'(errm_s1) * EIM_W'(ki_s1);
	assign ddp_c = DDP_W'(ddm_s1) * DDP_W'(kd_s1);

	// constant dividers: D term by tick period, integral step and P+D by 1000
	logic [DDP_W-1:0] dq;
	logic [ICS_W-1:0] iq_full;
	logic [PDM_W-1:0] pq_full;
	logic [IQ_W-1:0]  iq;
	logic [PQ_W-1:0]  pq;

	tpp_cdiv #(.NUM_W(DDP_W), .DIVISOR(TICK_PERIOD)) u_ddiv (
		.clk (clk),
		.en  ('{est: load[3], fix: load[4]}),
		.num (ddp_s2),
		.quo (dq)
	);

	tpp_cdiv #(.NUM_W(ICS_W), .DIVISOR(SCALE_ODD)) u_idiv (
		.clk (clk),
		.en  ('{est: load[4], fix: load[5]}),
		.num (icm_s3[IC_W-1:SCALE_SHIFT]),
		.quo (iq_full)
	);

	tpp_cdiv #(.NUM_W(PDM_W), .DIVISOR(SCALE_ODD)) u_pdiv (
		.clk (clk),
		.en  ('{est: load[7], fix: load[8]}),
		.num (pdm_s6),
		.quo (pq_full)
	);

	assign iq = iq_full[IQ_W-1:0];
	assign pq = pq_full[PQ_W-1:0];

	// stage 5: P + D, D truncated toward zero
	logic signed [PD_W-1:0] dval_c, pd_c;

	always_comb begin
		dval_c = PD_W'(dq);
		if (ddn_s4) dval_c = -dval_c;
		pd_c = PD_W'(p_s4) + dval_c;
	end

	// stage 6: |P + D| / 8, and the integral update (the integral's feedback loop)
	logic [PD_W-1:0]  pda_c;
	logic [INT_W-1:0] ibase_c;
	logic [INT_W:0]   isum_c;
	logic [INT_W-1:0] integ_c;

	always_comb begin
		pda_c   = pd_s5[PD_W-1] ? PD_W'(-pd_s5) : PD_W'(pd_s5);
		ibase_c = zint_s5 ? '0 : integral_q;
		if (ein_s5) begin
			isum_c = {ibase_c[INT_W-1], ibase_c} - (INT_W+1)'(iq);
		end else begin
			isum_c = {ibase_c[INT_W-1], ibase_c} + (INT_W+1)'(iq);
		end
		// saturate at the 32-bit signed limits
		if (isum_c[INT_W] != isum_c[INT_W-1]) begin
			integ_c = isum_c[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
		end else begin
			integ_c = isum_c[INT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (load[6]) begin
			integral_q <= integ_c;
		end
	end

	// stage 9: controller output = (P + D) / 1000 + integral
	logic signed [RES_W-1:0] res_c;

	always_comb begin
		if (pdn_s8) begin
			res_c = RES_W'({integ_s8[INT_W-1], integ_s8} - RES_W'(pq));
		end else begin
			res_c = RES_W'({integ_s8[INT_W-1], integ_s8} + RES_W'(pq));
		end
	end

	// stage 10: direction and clamped magnitude; zero counts as reverse
	logic                    res_pos_c;
	logic signed [RES_W-1:0] res_neg_c;
	logic [DSEL_W-1:0]       duty_c;

	always_comb begin
		res_pos_c = !res_s9[RES_W-1] && (res_s9 != '0);
		res_neg_c = -res_s9;
		if (res_pos_c) begin
			duty_c = (res_s9 > MAX_S) ? MAX_V : res_s9[DSEL_W-1:0];
		end else begin
			duty_c = (res_neg_c > MAX_S) ? MAX_V : res_neg_c[DSEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			err_s1  <= err_c;
			errm_s1 <= err_c[ERR_W-1] ? err_neg_c[ERR_MAG_W-1:0] : err_c[ERR_MAG_W-1:0];
			ein_s1  <= err_c[ERR_W-1];
			ddm_s1  <= diff_c[ERR_W] ? diff_neg_c[DIFF_MAG_W-1:0] : diff_c[DIFF_MAG_W-1:0];
			ddn_s1  <= diff_c[ERR_W];
			kp_s1   <= kp_c;
			ki_s1   <= ki_c;
			kd_s1   <= kd_c;
			zint_s1 <= zint_c;
		end
		if (load[2]) begin
			p_s2    <= p_c;
			eim_s2  <= eim_c;
			ddp_s2  <= ddp_c;
			ein_s2  <= ein_s1;
			ddn_s2  <= ddn_s1;
			zint_s2 <= zint_s1;
		end
		if (load[3]) begin
			p_s3    <= p_s2;
			icm_s3  <= IC_W'(eim_s2) * TICK_V;
			ein_s3  <= ein_s2;
			ddn_s3  <= ddn_s2;
			zint_s3 <= zint_s2;
		end
		if (load[4]) begin
			p_s4    <= p_s3;
			ein_s4  <= ein_s3;
			ddn_s4  <= ddn_s3;
			zint_s4 <= zint_s3;
		end
		if (load[5]) begin
			pd_s5   <= pd_c;
			ein_s5  <= ein_s4;
			zint_s5 <= zint_s4;
		end
		if (load[6]) begin
			pdm_s6   <= pda_c[PD_W-2:SCALE_SHIFT];
			pdn_s6   <= pd_s5[PD_W-1];
			integ_s6 <= integ_c;
		end
		if (load[7]) begin
			pdn_s7   <= pdn_s6;
			integ_s7 <= integ_s6;
		end
		if (load[8]) begin
			pdn_s8   <= pdn_s7;
			integ_s8 <= integ_s7;
		end
		if (load[9]) begin
			res_s9 <= res_c;
		end
		if (load[10]) begin
			duty_s10 <= duty_c[DUTY_W-1:0];
			rev_s10  <= !res_pos_c;
		end
	end

	assign drive.pwm_duty    = duty_s10;
	assign drive.reverse_dir = rev_s10;

	// ---- checks -----------------------------------------------------------------
	// one of the two sign-change flags is always armed
	a_pend_armed: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_pend_q || back_pend_q)
		else $error("both sign-change flags clear");

	// the integral moves only when an item passes the accumulate stage
	a_int_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load[6] |=> $stable(integral_q))
		else $error("integral changed without an item");

	// a fault clear always restarts the integral for that item
	a_clear_zint: assert property (@(posedge clk) disable iff (!arst_n)
		meas.valid && meas.ready && meas.clear_history |=> zint_s1)
		else $error("clear_history did not zero the integral");

	// presented duty never exceeds the limit when the limit fits the field
	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && (MAX_DUTY < (1 << DUTY_W)) |-> 32'(drive.pwm_duty) <= 32'(MAX_DUTY))
		else $error("duty above limit");

endmodule
